### hdl/hrbt_pkg.sv
package hrbt_pkg;

   localparam logic [7:0] CH_CR    = 8'h0d;
   localparam logic [7:0] CH_LF    = 8'h0a;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_COLON = 8'h3a;
   localparam logic [7:0] CH_QMARK = 8'h3f;

   localparam logic [3:0] TAG_METHOD  = 4'd0;
   localparam logic [3:0] TAG_PATH    = 4'd1;
   localparam logic [3:0] TAG_QUERY   = 4'd2;
   localparam logic [3:0] TAG_VERSION = 4'd3;
   localparam logic [3:0] TAG_HNAME   = 4'd4;
   localparam logic [3:0] TAG_HVALUE  = 4'd5;
   localparam logic [3:0] TAG_BODY    = 4'd6;
   localparam logic [3:0] TAG_SEP     = 4'd7;
   localparam logic [3:0] TAG_DISCARD = 4'd8;

   localparam logic [2:0] LS_NONE        = 3'd0;
   localparam logic [2:0] LS_REQ_OK      = 3'd1;
   localparam logic [2:0] LS_HDR_KEPT    = 3'd2;
   localparam logic [2:0] LS_HDR_DROPPED = 3'd3;
   localparam logic [2:0] LS_REQ_BAD     = 3'd4;
   localparam logic [2:0] LS_NO_EOL      = 3'd5;

   typedef enum logic [3:0] {
      PH_METHOD  = 4'd0,
      PH_PATH    = 4'd1,
      PH_QUERY   = 4'd2,
      PH_VERSION = 4'd3,
      PH_HNAME   = 4'd4,
      PH_HVALUE  = 4'd5,
      PH_BODY    = 4'd6,
      PH_HSKIP   = 4'd7,
      PH_DEAD    = 4'd8,
      PH_RLF     = 4'd9,
      PH_HLF     = 4'd10,
      PH_BLF     = 4'd11
   } phase_type;

   typedef struct packed {
      phase_type  phase;
      logic       line_has_colon;
      logic       line_empty;
      logic [4:0] header_count;
      logic       failed;
   } core_type;

   localparam core_type CORE_RESET = '{
      phase:          PH_METHOD,
      line_has_colon: 1'b0,
      line_empty:     1'b1,
      header_count:   5'd0,
      failed:         1'b0
   };

   typedef struct packed {
      logic [7:0] byte_out;
      logic [3:0] field_tag;
      logic [4:0] header_number;
      logic [2:0] line_status;
      logic       last_out;
   } result_type;

   typedef struct packed {
      core_type   st;
      result_type res;
   } step_type;

   function automatic step_type classify(core_type s, logic [7:0] b, logic next_lf,
                                         logic is_final, logic [4:0] hdr_cap);
      step_type r;
      logic     crlf;
      r = '{st: s, res: '0};
      crlf = (b == CH_CR) && next_lf;
      r.res.byte_out = b;
      r.res.field_tag = TAG_DISCARD;
      r.res.header_number = s.header_count;
      r.res.line_status = LS_NONE;
      r.res.last_out = is_final;
      case (s.phase)
         PH_METHOD, PH_PATH, PH_QUERY, PH_VERSION: begin
            if (crlf) begin
               r.res.field_tag = TAG_SEP;
               if (s.phase != PH_VERSION) r.st.failed = 1'b1;
               r.st.phase = PH_RLF;
            end else if (b == CH_SPACE && s.phase != PH_VERSION) begin
               r.res.field_tag = TAG_SEP;
               r.st.phase = (s.phase == PH_METHOD) ? PH_PATH : PH_VERSION;
            end else if (s.phase == PH_PATH && b == CH_QMARK) begin
               r.res.field_tag = TAG_QUERY;
               r.st.phase = PH_QUERY;
            end else begin
               r.res.field_tag = (s.phase == PH_METHOD) ? TAG_METHOD :
                                 (s.phase == PH_PATH)   ? TAG_PATH :
                                 (s.phase == PH_QUERY)  ? TAG_QUERY : TAG_VERSION;
            end
         end
         PH_RLF: begin
            r.res.field_tag = TAG_SEP;
            r.res.line_status = s.failed ? LS_REQ_BAD : LS_REQ_OK;
            r.st.phase = s.failed ? PH_DEAD : PH_HNAME;
            r.st.line_empty = 1'b1;
            r.st.line_has_colon = 1'b0;
         end
         PH_HNAME: begin
            if (crlf) begin
               r.res.field_tag = TAG_SEP;
               r.st.phase = s.line_empty ? PH_BLF : PH_HLF;
            end else if (b == CH_COLON) begin
               r.res.field_tag = TAG_SEP;
               r.st.line_has_colon = 1'b1;
               r.st.line_empty = 1'b0;
               r.st.phase = PH_HSKIP;
            end else begin
               r.res.field_tag = TAG_HNAME;
               r.st.line_empty = 1'b0;
            end
         end
         PH_HSKIP, PH_HVALUE: begin
            if (crlf) begin
               r.res.field_tag = TAG_SEP;
               r.st.phase = PH_HLF;
            end else if (s.phase == PH_HSKIP && b == CH_SPACE) begin
               r.res.field_tag = TAG_SEP;
            end else begin
               r.res.field_tag = TAG_HVALUE;
               r.st.phase = PH_HVALUE;
            end
         end
         PH_HLF: begin
            r.res.field_tag = TAG_SEP;
            r.res.line_status = s.line_has_colon ? LS_HDR_KEPT : LS_HDR_DROPPED;
            if (s.header_count < hdr_cap) r.st.header_count = s.header_count + 5'd1;
            r.st.line_has_colon = 1'b0;
            r.st.line_empty = 1'b1;
            r.st.phase = PH_HNAME;
         end
         PH_BLF: begin
            r.res.field_tag = TAG_SEP;
            r.st.phase = PH_BODY;
         end
         PH_BODY: begin
            r.res.field_tag = TAG_BODY;
         end
         default: begin
            r.res.field_tag = TAG_DISCARD;
         end
      endcase
      if (is_final && r.res.line_status == LS_NONE &&
          (s.phase inside {PH_METHOD, PH_PATH, PH_QUERY, PH_VERSION,
                           PH_HNAME, PH_HVALUE, PH_HSKIP}))
         r.res.line_status = LS_NO_EOL;
      return r;
   endfunction

endpackage

### hdl/hrbt_req_if.sv
interface hrbt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_in;
   logic       end_of_request;

   modport source (output valid, output byte_in, output end_of_request, input ready);
   modport sink (input valid, input byte_in, input end_of_request, output ready);
endinterface

### hdl/hrbt_rsp_if.sv
interface hrbt_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_out;
   logic [3:0] field_tag;
   logic [4:0] header_number;
   logic [2:0] line_status;
   logic       last_out;

   modport source (output valid, output byte_out, output field_tag, output header_number,
                   output line_status, output last_out, input ready);
   modport sink (input valid, input byte_out, input field_tag, input header_number,
                 input line_status, input last_out, output ready);
endinterface

### hdl/hrbt_result_fifo.sv
module hrbt_result_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [1:0]             push_count,
   input  hrbt_pkg::result_type   push_first,
   input  hrbt_pkg::result_type   push_second,
   output logic                   has_room,
   hrbt_rsp_if.source             rsp
);

   hrbt_pkg::result_type entry_ff [4];
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [2:0] count_ff, count_in;
   logic       pop;
   hrbt_pkg::result_type head;

   assign has_room = (count_ff <= 3'd2);
   assign pop      = rsp.valid && rsp.ready;
   assign head     = entry_ff[rd_ptr_ff];

   assign rsp.valid         = (count_ff != 3'd0);
   assign rsp.byte_out      = head.byte_out;
   assign rsp.field_tag     = head.field_tag;
   assign rsp.header_number = head.header_number;
   assign rsp.line_status   = head.line_status;
   assign rsp.last_out      = head.last_out;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + push_count;
      rd_ptr_in = rd_ptr_ff + {1'b0, pop};
      count_in  = count_ff + {1'b0, push_count} - {2'b00, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) entry_ff[wr_ptr_ff] <= push_first;
      if (push_count == 2'd2) entry_ff[wr_ptr_ff + 2'd1] <= push_second;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 3'd4) else $error("result fifo overfilled");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push_count != 2'd0 |-> count_ff <= 3'd2) else $error("push without room");

   a_push_max: assert property (@(posedge clock) disable iff (reset)
      push_count != 2'd3) else $error("more than two results in one beat");

   a_pop_only: assert property (@(posedge clock) disable iff (reset)
      pop && push_count == 2'd0 |=> count_ff == $past(count_ff) - 3'd1)
      else $error("pop did not drain one entry");

endmodule

### hdl/http_request_byte_tagger.sv
// HTTP request byte tagger.
// req: one request byte per beat (byte_in, end_of_request on the final byte).
// rsp: one tagged byte per beat (byte_out, field_tag, header_number,
//      line_status, last_out).
// A byte is held until the next beat arrives so a CR can be paired with a
// following LF; its result is queued at that next beat. The final beat of a
// request queues the held byte's result, if a byte is held, then the final
// byte's, and the tagger starts the next request from the method phase.
// A result is queued when the following byte (or the final byte itself) is
// accepted; the queue is registered, so the result reaches rsp in the cycle
// after at the earliest. Throughput: one byte per cycle while the queue has
// room; a request of N bytes yields N rsp beats. The four-entry result
// queue takes a beat only while it holds at most two results, so a stalled
// receiver holds off req after the queue fills; nothing is dropped.
// Reset (synchronous) empties the queue and returns the parser to the start
// of a request with no held byte.
module http_request_byte_tagger #(
   parameter int MAX_HEADERS = 32
) (
   input logic        clock,
   input logic        reset,
   hrbt_req_if.sink   req,
   hrbt_rsp_if.source rsp
);

   localparam int HdrCapInt = (MAX_HEADERS - 1 < 31) ? MAX_HEADERS - 1 : 31;
   localparam logic [4:0] HdrCap = 5'(HdrCapInt);

   hrbt_pkg::core_type   core_ff, core_in;
   logic [7:0]           held_byte_ff, held_byte_in;
   logic                 held_valid_ff, held_valid_in;
   hrbt_pkg::step_type   held_step, final_step;
   hrbt_pkg::core_type   final_base;
   hrbt_pkg::result_type push_first;
   logic [1:0]           push_count;
   logic                 has_room;
   logic                 accept;

   assign req.ready = has_room;
   assign accept    = req.valid && req.ready;

   always_comb begin
      held_step  = hrbt_pkg::classify(core_ff, held_byte_ff, req.byte_in == hrbt_pkg::CH_LF,
                                      1'b0, HdrCap);
      final_base = held_valid_ff ? held_step.st : core_ff;
      final_step = hrbt_pkg::classify(final_base, req.byte_in, 1'b0, 1'b1, HdrCap);
      push_first = held_valid_ff ? held_step.res : final_step.res;
      push_count = accept ? ({1'b0, held_valid_ff} + {1'b0, req.end_of_request}) : 2'd0;
   end

   always_comb begin
      core_in       = core_ff;
      held_byte_in  = held_byte_ff;
      held_valid_in = held_valid_ff;
      if (accept) begin
         if (req.end_of_request) begin
            core_in       = hrbt_pkg::CORE_RESET;
            held_byte_in  = 8'd0;
            held_valid_in = 1'b0;
         end else begin
            core_in       = final_base;
            held_byte_in  = req.byte_in;
            held_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         core_ff       <= hrbt_pkg::CORE_RESET;
         held_byte_ff  <= 8'd0;
         held_valid_ff <= 1'b0;
      end else begin
         core_ff       <= core_in;
         held_byte_ff  <= held_byte_in;
         held_valid_ff <= held_valid_in;
      end
   end

   hrbt_result_fifo u_fifo (
      .clock       (clock),
      .reset       (reset),
      .push_count  (push_count),
      .push_first  (push_first),
      .push_second (final_step.res),
      .has_room    (has_room),
      .rsp         (rsp)
   );

   a_eor_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req.end_of_request |=> !held_valid_ff && core_ff == hrbt_pkg::CORE_RESET)
      else $error("state not cleared after final byte");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      accept && !req.end_of_request |=> held_valid_ff && held_byte_ff == $past(req.byte_in))
      else $error("byte not held");

   a_hdr_cap: assert property (@(posedge clock) disable iff (reset)
      core_ff.header_count <= HdrCap) else $error("header count past cap");

endmodule

### test/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_HEADERS = 32;
   localparam logic [4:0] HDR_CAP = 5'((MAX_HEADERS - 1 < 31) ? MAX_HEADERS - 1 : 31);

   logic clock = 1'b0;
   logic reset;

   hrbt_req_if req_ch();
   hrbt_rsp_if rsp_ch();

   http_request_byte_tagger #(.MAX_HEADERS(MAX_HEADERS)) u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   always #4 clock = ~clock;

   // parser state as the tagger should see it
   hrbt_pkg::phase_type parse_phase;
   logic [7:0]          held_b;
   logic                held_ok;
   logic                saw_colon;
   logic                line_blank;
   logic [4:0]          hdr_idx;
   logic                bad_reqline;

   hrbt_pkg::result_type expected_tags[$];
   logic [7:0]           pending[$];
   int                   mismatches = 0;
   int                   src_idle_pct = 0;
   int                   snk_idle_pct = 0;

   task automatic note_mismatch(string what, int got, int want);
      $display("tb_top: mismatch %s got %0d want %0d at %0t", what, got, want, $realtime);
      mismatches++;
   endtask

   function automatic void clear_parser();
      parse_phase = hrbt_pkg::PH_METHOD;
      held_b      = 8'h00;
      held_ok     = 1'b0;
      saw_colon   = 1'b0;
      line_blank  = 1'b1;
      hdr_idx     = 5'd0;
      bad_reqline = 1'b0;
   endfunction

   // tag of an ordinary byte on the request line
   function automatic logic [3:0] reqline_tag(hrbt_pkg::phase_type ph);
      case (ph)
         hrbt_pkg::PH_METHOD: return hrbt_pkg::TAG_METHOD;
         hrbt_pkg::PH_PATH:   return hrbt_pkg::TAG_PATH;
         hrbt_pkg::PH_QUERY:  return hrbt_pkg::TAG_QUERY;
         default:             return hrbt_pkg::TAG_VERSION;
      endcase
   endfunction

   function automatic hrbt_pkg::result_type tag_byte(logic [7:0] b, logic lf_next,
                                                      logic is_last);
      hrbt_pkg::result_type r;
      hrbt_pkg::phase_type  ph0;
      logic                 at_eol;
      ph0    = parse_phase;
      at_eol = (b == hrbt_pkg::CH_CR) && lf_next;
      r.byte_out      = b;
      r.field_tag     = hrbt_pkg::TAG_DISCARD;
      r.header_number = hdr_idx;
      r.line_status   = hrbt_pkg::LS_NONE;
      r.last_out      = is_last;
      case (ph0)
         hrbt_pkg::PH_METHOD, hrbt_pkg::PH_PATH, hrbt_pkg::PH_QUERY,
         hrbt_pkg::PH_VERSION: begin
            if (at_eol) begin
               r.field_tag = hrbt_pkg::TAG_SEP;
               bad_reqline = bad_reqline | (ph0 != hrbt_pkg::PH_VERSION);
               parse_phase = hrbt_pkg::PH_RLF;
            end else if (b == hrbt_pkg::CH_SPACE && ph0 == hrbt_pkg::PH_METHOD) begin
               r.field_tag = hrbt_pkg::TAG_SEP;
               parse_phase = hrbt_pkg::PH_PATH;
            end else if (b == hrbt_pkg::CH_SPACE && ph0 != hrbt_pkg::PH_VERSION) begin
               r.field_tag = hrbt_pkg::TAG_SEP;
               parse_phase = hrbt_pkg::PH_VERSION;
            end else if (b == hrbt_pkg::CH_QMARK && ph0 == hrbt_pkg::PH_PATH) begin
               r.field_tag = hrbt_pkg::TAG_QUERY;
               parse_phase = hrbt_pkg::PH_QUERY;
            end else begin
               r.field_tag = reqline_tag(ph0);
            end
         end
         hrbt_pkg::PH_RLF: begin
            r.field_tag   = hrbt_pkg::TAG_SEP;
            r.line_status = bad_reqline ? hrbt_pkg::LS_REQ_BAD : hrbt_pkg::LS_REQ_OK;
            parse_phase   = bad_reqline ? hrbt_pkg::PH_DEAD : hrbt_pkg::PH_HNAME;
            line_blank    = 1'b1;
            saw_colon     = 1'b0;
         end
         hrbt_pkg::PH_HNAME: begin
            if (at_eol) begin
               r.field_tag = hrbt_pkg::TAG_SEP;
               parse_phase = line_blank ? hrbt_pkg::PH_BLF : hrbt_pkg::PH_HLF;
            end else if (b == hrbt_pkg::CH_COLON) begin
               r.field_tag = hrbt_pkg::TAG_SEP;
               saw_colon   = 1'b1;
               line_blank  = 1'b0;
               parse_phase = hrbt_pkg::PH_HSKIP;
            end else begin
               r.field_tag = hrbt_pkg::TAG_HNAME;
               line_blank  = 1'b0;
            end
         end
         hrbt_pkg::PH_HSKIP, hrbt_pkg::PH_HVALUE: begin
            if (at_eol) begin
               r.field_tag = hrbt_pkg::TAG_SEP;
               parse_phase = hrbt_pkg::PH_HLF;
            end else if (b == hrbt_pkg::CH_SPACE && ph0 == hrbt_pkg::PH_HSKIP) begin
               r.field_tag = hrbt_pkg::TAG_SEP;
            end else begin
               r.field_tag = hrbt_pkg::TAG_HVALUE;
               parse_phase = hrbt_pkg::PH_HVALUE;
            end
         end
         hrbt_pkg::PH_HLF: begin
            r.field_tag   = hrbt_pkg::TAG_SEP;
            r.line_status = saw_colon ? hrbt_pkg::LS_HDR_KEPT : hrbt_pkg::LS_HDR_DROPPED;
            if (hdr_idx < HDR_CAP) hdr_idx = hdr_idx + 5'd1;
            saw_colon   = 1'b0;
            line_blank  = 1'b1;
            parse_phase = hrbt_pkg::PH_HNAME;
         end
         hrbt_pkg::PH_BLF: begin
            r.field_tag = hrbt_pkg::TAG_SEP;
            parse_phase = hrbt_pkg::PH_BODY;
         end
         hrbt_pkg::PH_BODY: begin
            r.field_tag = hrbt_pkg::TAG_BODY;
         end
         default: begin
            r.field_tag = hrbt_pkg::TAG_DISCARD;
         end
      endcase
      // unterminated request line or header line
      if (is_last && r.line_status == hrbt_pkg::LS_NONE &&
          (ph0 <= hrbt_pkg::PH_HVALUE && ph0 != hrbt_pkg::PH_BODY ||
           ph0 == hrbt_pkg::PH_HSKIP))
         r.line_status = hrbt_pkg::LS_NO_EOL;
      return r;
   endfunction

   function automatic void track_beat(logic [7:0] b, logic eor);
      if (held_ok) expected_tags.push_back(tag_byte(held_b, b == hrbt_pkg::CH_LF, 1'b0));
      if (eor) begin
         expected_tags.push_back(tag_byte(b, 1'b0, 1'b1));
         clear_parser();
      end else begin
         held_b  = b;
         held_ok = 1'b1;
      end
   endfunction

   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
   end

   always @(posedge clock) begin
      hrbt_pkg::result_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (expected_tags.size() == 0) begin
            note_mismatch("unexpected beat, byte_out", int'(rsp_ch.byte_out), -1);
         end else begin
            want = expected_tags.pop_front();
            if (rsp_ch.byte_out !== want.byte_out)
               note_mismatch("byte_out", int'(rsp_ch.byte_out), int'(want.byte_out));
            if (rsp_ch.field_tag !== want.field_tag)
               note_mismatch("field_tag", int'(rsp_ch.field_tag), int'(want.field_tag));
            if (rsp_ch.header_number !== want.header_number)
               note_mismatch("header_number", int'(rsp_ch.header_number),
                             int'(want.header_number));
            if (rsp_ch.line_status !== want.line_status)
               note_mismatch("line_status", int'(rsp_ch.line_status),
                             int'(want.line_status));
            if (rsp_ch.last_out !== want.last_out)
               note_mismatch("last_out", int'(rsp_ch.last_out), int'(want.last_out));
         end
      end
   end

   task automatic send_beat(logic [7:0] b, logic eor);
      while ($urandom_range(99) < src_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid          <= 1'b1;
      req_ch.byte_in        <= b;
      req_ch.end_of_request <= eor;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) @(posedge clock);
      track_beat(b, eor);
   endtask

   task automatic send_request();
      int n;
      n = pending.size();
      for (int i = 0; i < n; i++) send_beat(pending[i], i == n - 1);
   endtask

   task automatic wait_drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (expected_tags.size() != 0) @(posedge clock);
   endtask

   function automatic void push_text(string s);
      for (int i = 0; i < s.len(); i++) pending.push_back(s[i]);
   endfunction

   function automatic void push_eol();
      pending.push_back(hrbt_pkg::CH_CR);
      pending.push_back(hrbt_pkg::CH_LF);
   endfunction

   // mostly printable, now and then any byte
   function automatic logic [7:0] text_byte();
      if ($urandom_range(0, 7) == 0) return 8'($urandom_range(0, 255));
      return 8'($urandom_range(33, 126));
   endfunction

   function automatic void make_request(int n_hdr, bit may_cut);
      int k;
      int kind;
      pending.delete();
      repeat ($urandom_range(1, 4)) pending.push_back(text_byte());
      pending.push_back(hrbt_pkg::CH_SPACE);
      push_text("/");
      repeat ($urandom_range(0, 4)) pending.push_back(text_byte());
      if ($urandom_range(0, 2) == 0) begin
         pending.push_back(hrbt_pkg::CH_QMARK);
         repeat ($urandom_range(0, 3)) pending.push_back(text_byte());
      end
      pending.push_back(hrbt_pkg::CH_SPACE);
      repeat ($urandom_range(1, 5)) begin
         case ($urandom_range(0, 5))
            0: pending.push_back(hrbt_pkg::CH_SPACE);
            1: begin
               pending.push_back(hrbt_pkg::CH_CR);
               pending.push_back(text_byte());
            end
            default: pending.push_back(text_byte());
         endcase
      end
      push_eol();
      for (k = 0; k < n_hdr; k++) begin
         kind = $urandom_range(0, 7);
         repeat ($urandom_range(1, 3)) pending.push_back(text_byte());
         if (kind != 0) begin
            pending.push_back(hrbt_pkg::CH_COLON);
            repeat ($urandom_range(0, 2)) pending.push_back(hrbt_pkg::CH_SPACE);
            if (kind != 1) repeat ($urandom_range(1, 4)) pending.push_back(text_byte());
         end
         push_eol();
      end
      if ($urandom_range(0, 7) != 0) begin
         push_eol();
         repeat ($urandom_range(0, 5)) pending.push_back(8'($urandom_range(0, 255)));
      end
      if (may_cut && $urandom_range(0, 5) == 0) begin
         k = $urandom_range(1, pending.size());
         while (pending.size() > k) void'(pending.pop_back());
      end
   endfunction

   function automatic void make_noise();
      pending.delete();
      repeat ($urandom_range(1, 10)) begin
         case ($urandom_range(0, 5))
            0: pending.push_back(hrbt_pkg::CH_CR);
            1: pending.push_back(hrbt_pkg::CH_LF);
            2: pending.push_back(hrbt_pkg::CH_SPACE);
            3: pending.push_back(hrbt_pkg::CH_COLON);
            4: pending.push_back(hrbt_pkg::CH_QMARK);
            default: pending.push_back(8'($urandom_range(0, 255)));
         endcase
      end
   endfunction

   task automatic test_request_line();
      pending.delete();
      push_text("G /?q H");
      push_eol();
      push_eol();
      pending.push_back(8'h00);
      pending.push_back(8'hff);
      send_request();
   endtask

   task automatic test_header_lines();
      pending.delete();
      push_text("  ");
      push_eol();
      push_text("A: ");
      push_eol();
      push_text("X");
      push_eol();
      push_text("K");
      send_request();
   endtask

   task automatic test_malformed_request();
      pending.delete();
      push_text("x");
      push_eol();
      pending.push_back(hrbt_pkg::CH_CR);
      send_request();
   endtask

   task automatic test_single_byte_request();
      pending.delete();
      pending.push_back(hrbt_pkg::CH_CR);
      send_request();
   endtask

   task automatic test_header_saturation();
      wait_drain();
      make_request(33, 1'b0);
      send_request();
   endtask

   task automatic test_random_requests(int n_bytes);
      int sent;
      sent = 0;
      while (sent < n_bytes) begin
         if ($urandom_range(0, 7) == 0) make_noise();
         else make_request($urandom_range(0, 4), 1'b1);
         sent += pending.size();
         send_request();
         if ($urandom_range(0, 9) == 0) wait_drain();
      end
   endtask

   initial begin
      reset                 <= 1'b1;
      req_ch.valid          <= 1'b0;
      req_ch.byte_in        <= 8'h00;
      req_ch.end_of_request <= 1'b0;
      clear_parser();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      src_idle_pct = 14;
      snk_idle_pct = 70;
      test_request_line();
      test_header_lines();
      test_malformed_request();
      test_single_byte_request();
      test_header_saturation();
      test_random_requests(30);

      src_idle_pct = 70;
      snk_idle_pct = 14;
      test_random_requests(30);

      src_idle_pct = 0;
      snk_idle_pct = 0;
      test_random_requests(30);

      wait_drain();
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

   initial begin
      #2ms;
      $display("tb_top: timeout");
      $display("tb_top: FAIL");
      $finish;
   end

endmodule

### http_request_byte_tagger.f
hdl/hrbt_pkg.sv
hdl/hrbt_req_if.sv
hdl/hrbt_rsp_if.sv
hdl/hrbt_result_fifo.sv
hdl/http_request_byte_tagger.sv
test/tb_top.sv
